// ===== sv/convex_polygon_fan_triangulator_defines.svh =====
// assertion macros for the fan triangulator
`ifndef CONVEX_POLYGON_FAN_TRIANGULATOR_DEFINES_SVH
`define CONVEX_POLYGON_FAN_TRIANGULATOR_DEFINES_SVH
// property must hold whenever reset is low
`define CPFT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked during reset too
`define CPFT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== sv/cpft_pkg.sv =====
`timescale 1ns / 1ps
package cpft_pkg;
  localparam int MaxVertsDef  = 16;
  localparam int IndexBitsDef = 24;
  localparam int CoordBits    = 32;
  localparam int DiffBits     = 33;
  localparam int ProdBits     = 66;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PLANE0, ST_PLANE1, ST_PLANE2, ST_MIN_RD, ST_MIN, ST_SORT_RD, ST_SORT_CMP0,
    ST_SORT_CMP1, ST_SORT_CMP2, ST_EMIT_RD, ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear_poly;
    logic plane_rd;
    logic plane_mul;
    logic plane_decide;
    logic min_rd;
    logic min_step;
    logic sort_rd;
    logic sort_c0;
    logic sort_c1;
    logic sort_c2;
    logic emit_rd;
    logic emit_go;
  } cmd_t;

  typedef struct packed {
    logic min_done;
    logic sort_pass_end;
    logic sort_done;
    logic emit_done;
    logic few;
  } stat_t;
endpackage

// ===== sv/cpft_ctrl.sv =====
`timescale 1ns / 1ps
module cpft_ctrl import cpft_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  close_req,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);
  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (close_req) state_next = ST_PLANE0;
      ST_PLANE0:    state_next = stat.few ? ST_EMIT_RD : ST_PLANE1;
      ST_PLANE1:    state_next = ST_PLANE2;
      ST_PLANE2:    state_next = ST_MIN_RD;
      ST_MIN_RD:    state_next = ST_MIN;
      ST_MIN:       state_next = stat.min_done ? ST_SORT_RD : ST_MIN_RD;
      ST_SORT_RD:   state_next = stat.sort_done ? ST_EMIT_RD : ST_SORT_CMP0;
      ST_SORT_CMP0: state_next = ST_SORT_CMP1;
      ST_SORT_CMP1: state_next = ST_SORT_CMP2;
      ST_SORT_CMP2: state_next = ST_SORT_RD;
      ST_EMIT_RD:   state_next = ST_EMIT;
      ST_EMIT:      state_next = stat.emit_done ? ST_IDLE : ST_EMIT_RD;
      default:      state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE:      ;
      ST_PLANE0:    cmd.plane_rd = 1'b1;
      ST_PLANE1:    cmd.plane_mul = 1'b1;
      ST_PLANE2:    cmd.plane_decide = 1'b1;
      ST_MIN_RD:    cmd.min_rd = 1'b1;
      ST_MIN:       cmd.min_step = 1'b1;
      ST_SORT_RD:   cmd.sort_rd = 1'b1;
      ST_SORT_CMP0: cmd.sort_c0 = 1'b1;
      ST_SORT_CMP1: cmd.sort_c1 = 1'b1;
      ST_SORT_CMP2: cmd.sort_c2 = 1'b1;
      ST_EMIT_RD:   cmd.emit_rd = 1'b1;
      ST_EMIT: begin
        cmd.emit_go = 1'b1;
        cmd.clear_poly = stat.emit_done;
      end
      default: ;
    endcase
  end
endmodule

// ===== sv/cpft_dp.sv =====
`timescale 1ns / 1ps
module cpft_dp import cpft_pkg::*; #(
  parameter int MAX_VERTS  = MaxVertsDef,
  parameter int INDEX_BITS = IndexBitsDef
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic [CoordBits-1:0]   in_x,
  input  logic [CoordBits-1:0]   in_y,
  input  logic [CoordBits-1:0]   in_z,
  input  logic [INDEX_BITS-1:0]  in_vi,
  input  logic [INDEX_BITS-1:0]  in_ni,
  input  logic [INDEX_BITS-1:0]  in_ti,
  input  logic [INDEX_BITS-1:0]  in_ci,
  input  logic [2:0]             in_flags,
  input  logic [15:0]            eps,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  output logic                   res_valid,
  output logic [INDEX_BITS-1:0]  res_vi,
  output logic [INDEX_BITS-1:0]  res_ni,
  output logic [INDEX_BITS-1:0]  res_ti,
  output logic [INDEX_BITS-1:0]  res_ci,
  output logic [2:0]             res_flags,
  output logic                   res_tri_end,
  output logic                   res_poly_end,
  output logic                   res_ovf
);
  localparam int SW = $clog2(MAX_VERTS);
  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam int XW = 4 * INDEX_BITS;

  // vertex memories
  logic signed [CoordBits-1:0] mem_x [MAX_VERTS];
  logic signed [CoordBits-1:0] mem_y [MAX_VERTS];
  logic signed [CoordBits-1:0] mem_z [MAX_VERTS];
  logic [XW-1:0]               mem_i [MAX_VERTS];

  // polygon state
  logic [CW-1:0] count;
  logic [2:0]    flags;
  logic          ovf;
  logic [SW-1:0] perm [MAX_VERTS];
  logic [1:0]    plane;    // 0 default zy, 1 xz, 2 xy
  logic [CW-1:0] pidx, jidx, lim;
  logic          swapped;
  logic signed [CoordBits-1:0] rd_x [3];
  logic signed [CoordBits-1:0] rd_y [3];
  logic signed [CoordBits-1:0] rd_z [3];
  logic signed [DiffBits-1:0]  dxa, dya, dxb, dyb;
  logic signed [ProdBits-1:0]  p0, p1, p2, p3;
  logic [DiffBits+15:0]        na_l, na_r, nb_l, nb_r;
  logic                        eqa, eqb;
  logic [CW-1:0]               emit_k;
  logic [1:0]                  corner;

  wire full = (count == CW'(MAX_VERTS));

  // store write and polygon bookkeeping
  always_ff @(posedge clk) begin
    if (load && !full) begin
      mem_x[count[SW-1:0]] <= in_x;
      mem_y[count[SW-1:0]] <= in_y;
      mem_z[count[SW-1:0]] <= in_z;
      mem_i[count[SW-1:0]] <= {in_ci, in_ti, in_ni, in_vi};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_poly) begin
      count <= '0;
      flags <= '0;
      ovf   <= 1'b0;
    end else if (load) begin
      if (count == '0) flags <= in_flags;
      if (full) ovf <= 1'b1;
      else count <= count + 1'b1;
    end
  end

  // selected axes of a slot
  function automatic logic signed [CoordBits-1:0] ax_of(
      input logic [1:0] pl, input logic signed [CoordBits-1:0] x,
      input logic signed [CoordBits-1:0] z);
    ax_of = (pl == 2'd0) ? z : x;
  endfunction
  function automatic logic signed [CoordBits-1:0] ay_of(
      input logic [1:0] pl, input logic signed [CoordBits-1:0] y,
      input logic signed [CoordBits-1:0] z);
    ay_of = (pl == 2'd1) ? z : y;
  endfunction

  logic [SW-1:0] ra0, ra1, ra2;
  always_comb begin
    ra0 = '0; ra1 = SW'(1); ra2 = SW'(2);
    if (cmd.min_rd) begin
      ra0 = perm[0]; ra1 = perm[pidx[SW-1:0]];
    end else if (cmd.sort_rd) begin
      ra0 = perm[0]; ra1 = perm[jidx[SW-1:0]];
      ra2 = perm[SW'(jidx + 1'b1)];
    end
  end

  // registered memory reads
  always_ff @(posedge clk) begin
    rd_x[0] <= mem_x[ra0]; rd_y[0] <= mem_y[ra0]; rd_z[0] <= mem_z[ra0];
    rd_x[1] <= mem_x[ra1]; rd_y[1] <= mem_y[ra1]; rd_z[1] <= mem_z[ra1];
    rd_x[2] <= mem_x[ra2]; rd_y[2] <= mem_y[ra2]; rd_z[2] <= mem_z[ra2];
  end

  // pivot search compares the pair read in the previous cycle
  wire signed [CoordBits-1:0] py0 = ay_of(plane, rd_y[0], rd_z[0]);
  wire signed [CoordBits-1:0] pyi = ay_of(plane, rd_y[1], rd_z[1]);

  function automatic logic [DiffBits-1:0] mag33(input logic signed [DiffBits-1:0] v);
    mag33 = v[DiffBits-1] ? DiffBits'(-v) : v;
  endfunction

  wire [DiffBits-1:0] eps33 = DiffBits'(eps);

  // multiply and compare pipeline, shared by plane choice and sort
  logic signed [DiffBits-1:0] m0a, m0b, m1a, m1b;
  always_comb begin
    if (cmd.plane_mul) begin
      m0a = DiffBits'(rd_z[0]) - DiffBits'(rd_z[1]);
      m0b = DiffBits'(rd_x[0]) - DiffBits'(rd_x[2]);
      m1a = DiffBits'(rd_x[0]) - DiffBits'(rd_x[1]);
      m1b = DiffBits'(rd_z[0]) - DiffBits'(rd_z[2]);
    end else begin
      m0a = dya; m0b = dxb; m1a = dyb; m1b = dxa;
    end
  end

  logic signed [DiffBits-1:0] tx, ty, bx, by;
  always_comb begin
    tx = DiffBits'(rd_x[0]) - DiffBits'(rd_x[1]);
    ty = DiffBits'(rd_y[0]) - DiffBits'(rd_y[1]);
    bx = DiffBits'(rd_x[0]) - DiffBits'(rd_x[2]);
    by = DiffBits'(rd_y[0]) - DiffBits'(rd_y[2]);
  end

  always_ff @(posedge clk) begin
    if (cmd.plane_mul || cmd.sort_c1) begin
      p0 <= ProdBits'(m0a) * ProdBits'(m0b);
      p1 <= ProdBits'(m1a) * ProdBits'(m1b);
      p2 <= ProdBits'(tx) * ProdBits'(by);
      p3 <= ProdBits'(ty) * ProdBits'(bx);
    end
    if (cmd.sort_c0) begin
      na_l <= {mag33(dya), 16'd0};
      na_r <= (DiffBits + 16)'(eps) * (DiffBits + 16)'(mag33(dxa));
      nb_l <= {mag33(dyb), 16'd0};
      nb_r <= (DiffBits + 16)'(eps) * (DiffBits + 16)'(mag33(dxb));
      eqa  <= mag33(dxa) <= eps33;
      eqb  <= mag33(dxb) <= eps33;
    end
  end

  logic signed [DiffBits-1:0] cxa, cya, cxb, cyb;
  always_comb begin
    cxa = DiffBits'(ax_of(plane, rd_x[1], rd_z[1])) - DiffBits'(ax_of(plane, rd_x[0], rd_z[0]));
    cya = DiffBits'(ay_of(plane, rd_y[1], rd_z[1])) - DiffBits'(ay_of(plane, rd_y[0], rd_z[0]));
    cxb = DiffBits'(ax_of(plane, rd_x[2], rd_z[2])) - DiffBits'(ax_of(plane, rd_x[0], rd_z[0]));
    cyb = DiffBits'(ay_of(plane, rd_y[2], rd_z[2])) - DiffBits'(ay_of(plane, rd_y[0], rd_z[0]));
  end

  logic signed [DiffBits-1:0] hxa, hya, hxb, hyb;
  always_ff @(posedge clk) begin
    if (cmd.sort_c0) begin
      hxa <= cxa; hya <= cya; hxb <= cxb; hyb <= cyb;
    end
  end
  always_comb begin
    if (cmd.sort_c0) begin
      dxa = cxa; dya = cya; dxb = cxb; dyb = cyb;
    end else begin
      dxa = hxa; dya = hya; dxb = hxb; dyb = hyb;
    end
  end

  // ordering decision
  logic in_ord;
  always_comb begin
    logic spa, snb, zna, znb;
    snb = (dyb != 0) && ((dyb < 0) == (dxb >= 0));
    spa = (dya != 0) && ((dya > 0) == (dxa >= 0));
    zna = na_l <= na_r;
    znb = nb_l <= nb_r;
    if (eqa) in_ord = snb || (znb && dxb < 0);
    else if (eqb) in_ord = spa || (zna && dxa > 0);
    else if (dxa < 0) in_ord = (dxb < 0) ? (p0 < p1) : 1'b0;
    else in_ord = (dxb < 0) ? 1'b1 : (p0 < p1);
  end

  // sequencing counters and permutation
  always_ff @(posedge clk) begin
    if (cmd.plane_rd) begin
      for (int i = 0; i < MAX_VERTS; i++) perm[i] <= SW'(i);
      plane   <= 2'd0;
      pidx    <= CW'(1);
      jidx    <= CW'(1);
      lim     <= count - 1'b1;
      swapped <= 1'b0;
      emit_k  <= '0;
      corner  <= '0;
    end
    if (cmd.plane_decide) begin
      if (p0 != p1) plane <= 2'd1;
      else if (p2 != p3) plane <= 2'd2;
    end
    if (cmd.min_step) begin
      if (py0 > pyi) begin
        perm[0] <= perm[pidx[SW-1:0]];
        perm[pidx[SW-1:0]] <= perm[0];
      end
      pidx <= pidx + 1'b1;
    end
    if (cmd.sort_c2) begin
      if (!in_ord) begin
        perm[jidx[SW-1:0]] <= perm[SW'(jidx + 1'b1)];
        perm[SW'(jidx + 1'b1)] <= perm[jidx[SW-1:0]];
      end
      if (jidx + 1'b1 >= lim) begin
        // a pass with no swap ends the sort
        jidx <= CW'(1);
        lim <= (swapped || !in_ord) ? lim - 1'b1 : CW'(1);
        swapped <= 1'b0;
      end else begin
        jidx <= jidx + 1'b1;
        swapped <= swapped || !in_ord;
      end
    end
    if (cmd.emit_go) begin
      if (stat.few) emit_k <= emit_k + 1'b1;
      else begin
        corner <= (corner == 2'd2) ? 2'd0 : corner + 1'b1;
        if (corner == 2'd0) emit_k <= emit_k + 1'b1;
        else if (corner == 2'd1) emit_k <= emit_k + 1'b1;
        else emit_k <= '0;
      end
    end
  end

  // fan order: corner 0 is pivot, then tri base + 1/2
  logic [CW-1:0] tri_base;
  always_ff @(posedge clk) begin
    if (cmd.plane_rd) tri_base <= '0;
    else if (cmd.emit_go && !stat.few && corner == 2'd2) tri_base <= tri_base + 1'b1;
  end
  logic [CW-1:0] emit_slot;
  always_comb begin
    if (stat.few) emit_slot = emit_k;
    else if (corner == 2'd0) emit_slot = '0;
    else if (corner == 2'd1) emit_slot = tri_base + 1'b1;
    else emit_slot = tri_base + CW'(2);
  end
  wire [SW-1:0] emit_addr = perm[emit_slot[SW-1:0]];
  logic [XW-1:0] erd;
  always_ff @(posedge clk) if (cmd.emit_rd) erd <= mem_i[emit_addr];

  wire last_few = (emit_k + 1'b1 == count);
  wire last_fan = (corner == 2'd2) && (tri_base + CW'(3) == count);
  always_comb begin
    stat.few           = (count <= CW'(3));
    stat.min_done      = (pidx + 1'b1 >= count);
    stat.sort_pass_end = (jidx + 1'b1 >= lim);
    stat.sort_done     = (lim <= CW'(1));
    stat.emit_done     = stat.few ? last_few : last_fan;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else res_valid <= cmd.emit_go;
    if (cmd.emit_go) begin
      res_vi       <= erd[INDEX_BITS-1:0];
      res_ni       <= flags[0] ? erd[2*INDEX_BITS-1:INDEX_BITS] : '0;
      res_ti       <= flags[1] ? erd[3*INDEX_BITS-1:2*INDEX_BITS] : '0;
      res_ci       <= flags[2] ? erd[4*INDEX_BITS-1:3*INDEX_BITS] : '0;
      res_flags    <= flags;
      res_tri_end  <= stat.few ? last_few : (corner == 2'd2);
      res_poly_end <= stat.emit_done;
      res_ovf      <= ovf;
    end
  end
endmodule

// ===== sv/convex_polygon_fan_triangulator.sv =====
`timescale 1ns / 1ps
// Fan triangulator for convex polygons. Vertices are loaded one per cycle
// while busy is low; the vertex with last_vertex set starts the work and busy
// rises. Polygons of three or fewer vertices are passed through. Larger ones
// take a plane choice, a pivot search over the vertices, a compare per
// bubble-sort step (up to (n-1)(n-2)/2 steps) and the emission of each
// corner. The threshold register takes writes only while busy is low.
// Results come with strobe high for one cycle each and can not be stalled;
// the receiver must take every one.
module convex_polygon_fan_triangulator import cpft_pkg::*; #(
  parameter int MAX_VERTS  = MaxVertsDef,
  parameter int INDEX_BITS = IndexBitsDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    coord_x,
  input  logic signed [31:0]    coord_y,
  input  logic signed [31:0]    coord_z,
  input  logic [INDEX_BITS-1:0] vertex_index,
  input  logic [INDEX_BITS-1:0] normal_index,
  input  logic [INDEX_BITS-1:0] texcoord_index,
  input  logic [INDEX_BITS-1:0] color_index,
  input  logic                  has_normal,
  input  logic                  has_texcoord,
  input  logic                  has_color,
  input  logic                  last_vertex,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_data,
  output logic                  strobe,
  output logic [INDEX_BITS-1:0] out_vertex_index,
  output logic [INDEX_BITS-1:0] out_normal_index,
  output logic [INDEX_BITS-1:0] out_texcoord_index,
  output logic [INDEX_BITS-1:0] out_color_index,
  output logic                  normal_valid,
  output logic                  texcoord_valid,
  output logic                  color_valid,
  output logic                  triangle_end,
  output logic                  polygon_end,
  output logic                  overflow
);
`include "convex_polygon_fan_triangulator_defines.svh"
  cmd_t       cmd;
  stat_t      stat;
  logic [15:0] epsilon_threshold;
  logic [2:0] rflags;
  wire        load = start && !busy;

  // tolerance register, written only while idle
  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (rst) epsilon_threshold <= 16'd1;
    else if (cfg_valid && cfg_ready) epsilon_threshold <= cfg_data;
  end

  cpft_ctrl u_ctrl (
    .clk, .rst, .close_req(load && last_vertex), .stat, .cmd, .busy
  );

  cpft_dp #(.MAX_VERTS(MAX_VERTS), .INDEX_BITS(INDEX_BITS)) u_dp (
    .clk, .rst, .load,
    .in_x(coord_x), .in_y(coord_y), .in_z(coord_z),
    .in_vi(vertex_index), .in_ni(normal_index), .in_ti(texcoord_index),
    .in_ci(color_index), .in_flags({has_color, has_texcoord, has_normal}),
    .eps(epsilon_threshold), .cmd, .stat,
    .res_valid(strobe), .res_vi(out_vertex_index), .res_ni(out_normal_index),
    .res_ti(out_texcoord_index), .res_ci(out_color_index), .res_flags(rflags),
    .res_tri_end(triangle_end), .res_poly_end(polygon_end), .res_ovf(overflow)
  );
  assign normal_valid   = rflags[0];
  assign texcoord_valid = rflags[1];
  assign color_valid    = rflags[2];

  `CPFT_ASSERT(a_end_tri, strobe && polygon_end |-> triangle_end, "polygon end without triangle end")
  `CPFT_ASSERT(a_strobe_busy, strobe && !polygon_end |-> busy, "result outside busy period")
  `CPFT_ASSERT_ALWAYS(a_rst_idle, rst |=> !busy && !strobe, "not idle after reset")
endmodule
